// ===== src/itoa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg: shared types, constants and helpers of the integer to ASCII formatter
// This package holds the conversion selector codes, the sequencer state type
// and the character tables that the formatter uses.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Conversion selector codes. Codes five to seven select no conversion.
  typedef enum logic [2:0] {
    FN_DEC_S  = 3'd0,
    FN_DEC_U  = 3'd1,
    FN_HEX_LO = 3'd2,
    FN_HEX_HI = 3'd3,
    FN_PTR    = 3'd4
  } func_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned WordW   = 32;
  localparam int unsigned BcdDigs = 10;
  localparam int unsigned NibDigs = ValueW / 4;
  localparam int unsigned TextMax = 18;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;

  localparam logic [2:0] PfxNone = 3'd0;
  localparam logic [2:0] PfxSign = 3'd1;
  localparam logic [2:0] PfxHex  = 3'd2;
  localparam logic [2:0] PfxNil  = 3'd5;

  // ASCII code of one digit in base ten or sixteen.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? ChUpA : ChLowA;
      if (d < 4'd10) begin
        digit_char = ChZero + {4'h0, d};
      end else begin
        digit_char = base + {4'h0, d} - 8'd10;
      end
    end
  endfunction

  // Characters of the null pointer text.
  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    begin
      case (idx)
        3'd0:    nil_char = 8'h28;
        3'd1:    nil_char = 8'h6E;
        3'd2:    nil_char = 8'h69;
        3'd3:    nil_char = 8'h6C;
        3'd4:    nil_char = 8'h29;
        default: nil_char = 8'h3F;
      endcase
    end
  endfunction

  // Index of the most significant nonzero nibble, zero for an all-zero word.
  function automatic logic [3:0] msd_index(input logic [ValueW-1:0] w);
    logic [3:0] top;
    begin
      top = 4'd0;
      for (int i = 0; i < NibDigs; i++) begin
        if (w[i*4 +: 4] != 4'h0) begin
          top = 4'(i);
        end
      end
      msd_index = top;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/integer_to_ascii_formatter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit: printf-style integer to ASCII text
// Formats one value per item as signed or unsigned decimal, lower or upper
// case hex, or a pointer, and sends its characters most significant first.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   value[63:0], func[2:0]
//  output   out_valid / out_ready char_code[7:0], is_last, char_count[4:0]
//
//  Each item transfers in the idle state. Decimal items then shift every
//  bit of the low word through the shift-and-add-3 BCD unit and then find
//  the leading digit; hex and pointer items only find the leading digit,
//  and a null pointer goes straight to its text. The characters then go out
//  in order. The input is ready only when idle; a stalled output holds the
//  emit state.
module integer_to_ascii_formatter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] value,
  input  wire logic [2:0]  func,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       char_code,
  output logic             is_last,
  output logic [4:0]       char_count
);

  itoa_pkg::state_t state;
  itoa_pkg::state_t state_next;
  itoa_pkg::func_t  mode;
  itoa_pkg::func_t  in_func;

  logic [itoa_pkg::ValueW-1:0] work;
  logic [itoa_pkg::ValueW-1:0] work_adj;
  logic [itoa_pkg::WordW-1:0]  src;
  logic [itoa_pkg::WordW-1:0]  low;
  logic [4:0] bit_cnt;
  logic [3:0] dig_idx;
  logic [2:0] pfx_idx;
  logic [2:0] pfx_len;
  logic       in_pfx;
  logic       neg;
  logic       nil;
  logic [4:0] char_cnt;

  logic       conv_en;
  logic       find_en;
  logic       emit_go;
  logic       accept;
  logic       pfx_last;
  logic       last_now;
  logic [3:0] cur_digit;
  logic [7:0] cur_char;
  logic       is_dec;

  assign in_func  = itoa_pkg::func_t'(func);
  assign low      = value[itoa_pkg::WordW-1:0];
  assign accept   = in_valid && in_ready;
  assign is_dec   = (mode == itoa_pkg::FN_DEC_S) || (mode == itoa_pkg::FN_DEC_U);

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            itoa_pkg::FN_DEC_S, itoa_pkg::FN_DEC_U: state_next = itoa_pkg::ST_CONV;
            itoa_pkg::FN_HEX_LO, itoa_pkg::FN_HEX_HI: state_next = itoa_pkg::ST_FIND;
            itoa_pkg::FN_PTR: begin
              state_next = (value == '0) ? itoa_pkg::ST_EMIT : itoa_pkg::ST_FIND;
            end
            default: state_next = itoa_pkg::ST_IDLE;
          endcase
        end
      end
      itoa_pkg::ST_CONV: begin
        if (bit_cnt == 5'd0) begin
          state_next = itoa_pkg::ST_FIND;
        end
      end
      itoa_pkg::ST_FIND: state_next = itoa_pkg::ST_EMIT;
      itoa_pkg::ST_EMIT: begin
        if (emit_go && last_now) begin
          state_next = itoa_pkg::ST_IDLE;
        end
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    conv_en  = 1'b0;
    find_en  = 1'b0;
    emit_go  = 1'b0;
    case (state)
      itoa_pkg::ST_IDLE: in_ready = 1'b1;
      itoa_pkg::ST_CONV: conv_en  = 1'b1;
      itoa_pkg::ST_FIND: find_en  = 1'b1;
      itoa_pkg::ST_EMIT: emit_go  = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  // Shared BCD step: every decimal digit of five or more gets three added.
  always_comb begin
    work_adj = work;
    for (int i = 0; i < itoa_pkg::BcdDigs; i++) begin
      if (work[i*4 +: 4] >= 4'd5) begin
        work_adj[i*4 +: 4] = work[i*4 +: 4] + 4'd3;
      end
    end
  end

  // Character selection for the current position.
  assign pfx_last  = (pfx_idx == (pfx_len - 3'd1));
  assign last_now  = in_pfx ? (nil && pfx_last) : (dig_idx == 4'd0);
  assign cur_digit = work[{dig_idx, 2'b00} +: 4];

  always_comb begin
    if (in_pfx) begin
      if (nil) begin
        cur_char = itoa_pkg::nil_char(pfx_idx);
      end else if (neg) begin
        cur_char = itoa_pkg::ChMinus;
      end else if (pfx_idx == 3'd0) begin
        cur_char = itoa_pkg::ChZero;
      end else begin
        cur_char = itoa_pkg::ChLowX;
      end
    end else begin
      cur_char = itoa_pkg::digit_char(cur_digit, mode == itoa_pkg::FN_HEX_HI);
    end
  end

  // Datapath registers: load, convert, find the leading digit, step the text.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode     <= in_func;
      neg      <= (in_func == itoa_pkg::FN_DEC_S) && low[itoa_pkg::WordW-1];
      nil      <= (in_func == itoa_pkg::FN_PTR) && (value == '0);
      pfx_idx  <= 3'd0;
      char_cnt <= 5'd0;
      bit_cnt  <= 5'(itoa_pkg::WordW - 1);
      src      <= ((in_func == itoa_pkg::FN_DEC_S) && low[itoa_pkg::WordW-1]) ?
                  (~low + 32'd1) : low;
      if (in_func == itoa_pkg::FN_PTR) begin
        work    <= value;
        pfx_len <= (value == '0) ? itoa_pkg::PfxNil : itoa_pkg::PfxHex;
        in_pfx  <= 1'b1;
      end else if ((in_func == itoa_pkg::FN_HEX_LO) || (in_func == itoa_pkg::FN_HEX_HI)) begin
        work    <= {32'h0, low};
        pfx_len <= itoa_pkg::PfxNone;
        in_pfx  <= 1'b0;
      end else begin
        work    <= '0;
        pfx_len <= ((in_func == itoa_pkg::FN_DEC_S) && low[itoa_pkg::WordW-1]) ?
                   itoa_pkg::PfxSign : itoa_pkg::PfxNone;
        in_pfx  <= (in_func == itoa_pkg::FN_DEC_S) && low[itoa_pkg::WordW-1];
      end
    end
    if (conv_en) begin
      work    <= {work_adj[itoa_pkg::ValueW-2:0], src[itoa_pkg::WordW-1]};
      src     <= {src[itoa_pkg::WordW-2:0], 1'b0};
      bit_cnt <= bit_cnt - 5'd1;
    end
    if (find_en) begin
      dig_idx <= itoa_pkg::msd_index(work);
    end
    if (emit_go) begin
      char_cnt <= char_cnt + 5'd1;
      if (in_pfx) begin
        if (pfx_last) begin
          in_pfx <= 1'b0;
        end else begin
          pfx_idx <= pfx_idx + 3'd1;
        end
      end else begin
        dig_idx <= dig_idx - 4'd1;
      end
    end
  end

  // Output register: a new character loads when the previous one has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      char_code  <= cur_char;
      is_last    <= last_now;
      char_count <= char_cnt + 5'd1;
    end
  end

  // A decimal conversion only ever produces digits zero to nine.
  a_dec_digit: assert property (@(posedge clk) disable iff (rst)
    (emit_go && !in_pfx && is_dec) |-> (cur_digit <= 4'd9))
    else $error("decimal digit out of range");

  // The BCD unit never carries into the nibbles above ten digits.
  a_bcd_width: assert property (@(posedge clk) disable iff (rst)
    conv_en |-> (work[itoa_pkg::ValueW-1:itoa_pkg::BcdDigs*4] == '0))
    else $error("BCD overflow during conversion");

  // The text never runs past its longest length.
  a_text_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (char_count == 5'(itoa_pkg::TextMax))) |-> is_last)
    else $error("text longer than the longest conversion");

endmodule
`default_nettype wire

// ===== bench/tb_integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_unit: self-checking bench for the formatter
// Sends values with every conversion selector, works out the characters that
// each one must produce, and checks every output transfer against them in
// order. Both channels idle at random in the first two phases, and once the
// output holds off long enough for the input to back up.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_unit;

  // Selector codes that select no conversion.
  localparam logic [2:0] FN_UNUSED_LO  = 3'd5;
  localparam logic [2:0] FN_UNUSED_MID = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI  = 3'd7;

  // Idling phases.
  localparam int PH_SEND_RARE = 0;
  localparam int PH_RECV_RARE = 1;
  localparam int PH_STEADY    = 2;

  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  func;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic [4:0] count;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] value = '0;
  logic [2:0]  func = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  char_code;
  logic        is_last;
  logic [4:0]  char_count;

  fmt_req_t   pending_reqs[$];
  text_char_t text_due[$];
  int         phase = PH_SEND_RARE;
  int         err_cnt = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  integer_to_ascii_formatter_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .is_last    (is_last),
    .char_count (char_count)
  );

  always #5 clk = ~clk;

  // Work out the text of one accepted item and queue its characters.
  function automatic void format_text(input logic [63:0] v, input logic [2:0] f);
    byte unsigned txt[$];
    byte unsigned digs[$];
    logic [63:0]  mag;
    logic [63:0]  radix;
    logic [31:0]  neg;
    string        digit_set;
    string        nil_str;
    bit           numeric;
    text_char_t   c;
    mag = '0;
    radix = 64'd10;
    digit_set = "0123456789abcdef";
    nil_str = "(nil)";
    numeric = 1'b1;
    case (f)
      itoa_pkg::FN_DEC_S: begin
        mag = {32'd0, v[31:0]};
        if (v[31]) begin
          txt.push_back("-");
          neg = ~v[31:0] + 32'd1;
          mag = {32'd0, neg};
        end
      end
      itoa_pkg::FN_DEC_U: mag = {32'd0, v[31:0]};
      itoa_pkg::FN_HEX_LO: begin
        mag = {32'd0, v[31:0]};
        radix = 64'd16;
      end
      itoa_pkg::FN_HEX_HI: begin
        mag = {32'd0, v[31:0]};
        radix = 64'd16;
        digit_set = "0123456789ABCDEF";
      end
      itoa_pkg::FN_PTR: begin
        if (v == 64'd0) begin
          numeric = 1'b0;
          for (int i = 0; i < nil_str.len(); i++) txt.push_back(nil_str[i]);
        end else begin
          txt.push_back("0");
          txt.push_back("x");
          mag = v;
          radix = 64'd16;
        end
      end
      default: numeric = 1'b0;
    endcase
    // Digits come out least significant first, so build them in reverse.
    if (numeric) begin
      do begin
        digs.push_front(digit_set[int'(mag % radix)]);
        mag = mag / radix;
      end while (mag != 64'd0);
      foreach (digs[i]) txt.push_back(digs[i]);
    end
    foreach (txt[i]) begin
      c.code = txt[i];
      c.last = (i == txt.size() - 1);
      c.count = 5'(i + 1);
      text_due.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic bit sender_gap();
    case (phase)
      PH_SEND_RARE: return $urandom_range(0, 99) < 7;
      PH_RECV_RARE: return $urandom_range(0, 99) < 84;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (phase)
      PH_SEND_RARE: return $urandom_range(0, 99) < 84;
      PH_RECV_RARE: return $urandom_range(0, 99) < 7;
      default:      return 1'b0;
    endcase
  endfunction

  // Input driver: predicts on each transfer and offers the next pending item.
  always @(posedge clk) begin : drv_blk
    fmt_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) format_text(value, func);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && !sender_gap()) begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          value <= req.value;
          func <= req.func;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, once, early in the steady phase.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (phase == PH_STEADY && !hold_done && out_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: compares each character transfer with the oldest one due.
  always @(posedge clk) begin : mon_blk
    text_char_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (text_due.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with none due", char_code));
        end else begin
          want = text_due.pop_front();
          if (char_code !== want.code)
            report_mismatch($sformatf("char_code 0x%02h, want 0x%02h", char_code, want.code));
          if (is_last !== want.last)
            report_mismatch($sformatf("is_last %b, want %b", is_last, want.last));
          if (char_count !== want.count)
            report_mismatch($sformatf("char_count %0d, want %0d", char_count, want.count));
        end
      end
      out_ready <= (hold_left == 0) && !receiver_stall();
    end
  end

  task automatic add_item(input logic [63:0] v, input logic [2:0] f);
    fmt_req_t r;
    r.value = v;
    r.func = f;
    pending_reqs.push_back(r);
  endtask

  // Random items; unused selectors are mixed in but do not count.
  task automatic add_random_items(input int n);
    logic [63:0] v;
    logic [2:0]  f;
    int          made;
    made = 0;
    while (made < n) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: ;
        1: v = v >> $urandom_range(0, 63);
        2: v[31:0] = v[31:0] >> $urandom_range(0, 31);
        3: v[31:0] = ~(v[31:0] >> $urandom_range(1, 31));
        default: v = 64'($urandom_range(0, 17));
      endcase
      if ($urandom_range(0, 99) < 6) begin
        f = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      end else begin
        f = 3'($urandom_range(itoa_pkg::FN_DEC_S, itoa_pkg::FN_PTR));
        made++;
      end
      add_item(v, f);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || text_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, every conversion, most negative value, null
    // pointer, and the selectors that produce nothing.
    add_item(64'd0, itoa_pkg::FN_DEC_S);
    add_item(64'h0000_0000_0000_0001, itoa_pkg::FN_DEC_S);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FN_DEC_S);
    add_item(64'h0000_0000_7FFF_FFFF, itoa_pkg::FN_DEC_S);
    add_item(64'hFFFF_FFFF_8000_0000, itoa_pkg::FN_DEC_S);
    add_item(64'h0000_0000_8000_0001, itoa_pkg::FN_DEC_S);
    add_item(64'd0, itoa_pkg::FN_DEC_U);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FN_DEC_U);
    add_item(64'h0000_0000_3B9A_CA00, itoa_pkg::FN_DEC_U);
    add_item(64'hA5A5_A5A5_0000_0009, itoa_pkg::FN_DEC_U);
    add_item(64'd0, itoa_pkg::FN_HEX_LO);
    add_item(64'h1234_5678_DEAD_BEEF, itoa_pkg::FN_HEX_LO);
    add_item(64'h0000_0000_FFFF_FFFF, itoa_pkg::FN_HEX_LO);
    add_item(64'd0, itoa_pkg::FN_HEX_HI);
    add_item(64'h0000_0000_ABCD_EF12, itoa_pkg::FN_HEX_HI);
    add_item(64'hFFFF_FFFF_0000_000F, itoa_pkg::FN_HEX_HI);
    add_item(64'd0, itoa_pkg::FN_PTR);
    add_item(64'd1, itoa_pkg::FN_PTR);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, itoa_pkg::FN_PTR);
    add_item(64'h1234_5678_9ABC_DEF0, itoa_pkg::FN_PTR);
    add_item(64'h0000_0001_0000_0000, itoa_pkg::FN_PTR);
    add_item(64'h8000_0000_0000_0000, itoa_pkg::FN_PTR);
    add_item(64'h0000_0000_0000_0005, FN_UNUSED_LO);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, FN_UNUSED_MID);
    add_item(64'd0, FN_UNUSED_HI);

    add_random_items(125);
    wait_drained();
    phase = PH_RECV_RARE;
    add_random_items(125);
    wait_drained();
    phase = PH_STEADY;
    add_random_items(130);
    wait_drained();

    // Let any late or stray character show up before the verdict.
    repeat (60) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
